@@ rtl/qrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants and types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int ROOT_WIDTH = 34;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_ONE   = 2'd1,
    ST_TWO   = 2'd2,
    ST_DEGEN = 2'd3
  } status_t;

  // One finished result as it leaves the pipeline.
  typedef struct packed {
    status_t                        status;
    logic signed [ROOT_WIDTH-1:0]   lo;
    logic signed [ROOT_WIDTH-1:0]   hi;
  } result_t;

endpackage

@@ rtl/quadratic_root_solver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 in signed fixed point.
// ----------------------------------------------------------------------------
// The solver takes one set of coefficients per beat and returns one result
// beat per input beat, in order: the root count and the two roots in
// ascending order, with FRAC_BITS fraction bits and truncated toward zero.
// It is fully pipelined and accepts a new beat in every cycle while the
// result buffer has room. Its depth is set by the bit-per-stage square root
// and the bit-per-stage dividers. The whole pipeline advances together and
// stalls only when the two-entry result buffer is full.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COEF_WIDTH-1:0]          coef_a,
  input  logic signed [COEF_WIDTH-1:0]          coef_b,
  input  logic signed [COEF_WIDTH-1:0]          coef_c,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            root_status,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_low,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_high
);

  // Widths of the arithmetic. The square root yields sqrt(D) with FRAC_BITS
  // fraction bits; the numerators are -b * 2^F plus or minus that root.
  localparam int W   = COEF_WIDTH;
  localparam int QW  = W + 1 + FRAC_BITS;
  localparam int RW  = 2 * QW;
  localparam int SCW = W + FRAC_BITS + 1;
  localparam int NW  = W + FRAC_BITS + 3;
  localparam int DNW = W + 1;
  localparam int SW  = 1 + 2 + DNW + 2 * SCW;

  logic en;

  // Front end outputs.
  logic                  f_valid, f_az;
  logic [RW-1:0]         f_rad;
  qrs_pkg::status_t      f_status;
  logic signed [DNW-1:0] f_den;
  logic signed [SCW-1:0] f_nb, f_nc;

  // Square root outputs.
  logic                  s_valid;
  logic [QW-1:0]         s_root;
  logic [SW-1:0]         s_side;
  logic                  s_az;
  logic [1:0]            s_status;
  logic signed [DNW-1:0] s_den;
  logic signed [SCW-1:0] s_nb, s_nc;
  logic signed [NW-1:0]  nb_ext, root_ext;

  // Numerator preparation stage.
  logic                  p_valid;
  logic signed [NW-1:0]  p_num1, p_num2;
  logic signed [DNW-1:0] p_den;
  logic [1:0]            p_status;

  // Divider and back end.
  logic                  d_valid;
  logic signed [NW:0]    d_q1, d_q2;
  logic [1:0]            d_status;
  logic                  b_valid;
  qrs_pkg::result_t      b_result, o_result;
  logic                  buf_full;

  // The result buffer takes whatever leaves the pipeline while it has room,
  // so the pipeline may only move when the buffer is not full.
  assign en = !buf_full;
  assign in_ready = en;

  qrs_front #(
    .COEF_WIDTH (COEF_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .coef_a    (coef_a),
    .coef_b    (coef_b),
    .coef_c    (coef_c),
    .out_valid (f_valid),
    .rad       (f_rad),
    .a_zero    (f_az),
    .status    (f_status),
    .den       (f_den),
    .nb_sc     (f_nb),
    .nc_sc     (f_nc)
  );

  qrs_isqrt #(
    .ROOT_BITS  (QW),
    .SIDE_WIDTH (SW)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .rad       (f_rad),
    .side_in   ({f_az, f_status, f_den, f_nb, f_nc}),
    .out_valid (s_valid),
    .root      (s_root),
    .side_out  (s_side)
  );

  assign {s_az, s_status, s_den, s_nb, s_nc} = s_side;
  assign nb_ext = {{(NW-SCW){s_nb[SCW-1]}}, s_nb};
  assign root_ext = {{(NW-QW){1'b0}}, s_root};

  // For a linear equation the first divider works out -c * 2^F / b and the
  // second one carries a result that is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_num1 <= s_az ? {{(NW-SCW){s_nc[SCW-1]}}, s_nc} : nb_ext + root_ext;
      p_num2 <= nb_ext - root_ext;
      p_den <= s_den;
      p_status <= s_status;
    end
  end

  qrs_div #(
    .NUM_WIDTH  (NW),
    .DEN_WIDTH  (DNW),
    .SIDE_WIDTH (2)
  ) u_div_plus (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .num       (p_num1),
    .den       (p_den),
    .side_in   (p_status),
    .out_valid (d_valid),
    .quot      (d_q1),
    .side_out  (d_status)
  );

  qrs_div #(
    .NUM_WIDTH  (NW),
    .DEN_WIDTH  (DNW),
    .SIDE_WIDTH (2)
  ) u_div_minus (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .num       (p_num2),
    .den       (p_den),
    .side_in   (p_status),
    .out_valid (),
    .quot      (d_q2),
    .side_out  ()
  );

  qrs_back #(
    .QUOT_WIDTH (NW + 1)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .quot1     (d_q1),
    .quot2     (d_q2),
    .status    (qrs_pkg::status_t'(d_status)),
    .out_valid (b_valid),
    .result    (b_result)
  );

  qrs_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (b_valid && en),
    .wdata     (b_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rdata     (o_result)
  );

  assign root_status = o_result.status;
  assign root_low = o_result.lo;
  assign root_high = o_result.hi;

endmodule

@@ rtl/qrs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_front
// Products, discriminant, case selection and scaled operands (3 stages).
// ----------------------------------------------------------------------------
module qrs_front #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS,
  localparam int RAD_WIDTH = 2 * (COEF_WIDTH + 1 + FRAC_BITS),
  localparam int SC_WIDTH  = COEF_WIDTH + FRAC_BITS + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [COEF_WIDTH-1:0] coef_a,
  input  logic signed [COEF_WIDTH-1:0] coef_b,
  input  logic signed [COEF_WIDTH-1:0] coef_c,
  output logic                        out_valid,
  output logic [RAD_WIDTH-1:0]        rad,
  output logic                        a_zero,
  output qrs_pkg::status_t            status,
  output logic signed [COEF_WIDTH:0]  den,
  output logic signed [SC_WIDTH-1:0]  nb_sc,
  output logic signed [SC_WIDTH-1:0]  nc_sc
);

  localparam int W  = COEF_WIDTH;
  localparam int PW = 2 * W;
  localparam int DW = 2 * W + 3;
  localparam int MW = 2 * W + 1;

  logic                 v1, v2;
  logic signed [W-1:0]  a1, b1, c1, a2, b2, c2;
  logic signed [PW-1:0] bb2, ac2;
  logic                 az2, bz2;

  logic signed [DW-1:0] d;
  logic                 d_neg, d_zero;
  qrs_pkg::status_t     status_next;
  logic signed [SC_WIDTH-1:0] b_sc, c_sc;

  assign d = {{3{bb2[PW-1]}}, bb2} - {ac2[PW-1], ac2, 2'b00};
  assign d_neg = d[DW-1];
  assign d_zero = (d == '0);
  assign b_sc = {{(SC_WIDTH-W){b2[W-1]}}, b2} <<< FRAC_BITS;
  assign c_sc = {{(SC_WIDTH-W){c2[W-1]}}, c2} <<< FRAC_BITS;

  always_comb begin
    priority if (az2 && bz2) begin
      status_next = qrs_pkg::ST_DEGEN;
    end else if (az2) begin
      status_next = qrs_pkg::ST_ONE;
    end else if (d_neg) begin
      status_next = qrs_pkg::ST_NONE;
    end else if (d_zero) begin
      status_next = qrs_pkg::ST_ONE;
    end else begin
      status_next = qrs_pkg::ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= coef_a;
      b1 <= coef_b;
      c1 <= coef_c;
      bb2 <= b1 * b1;
      ac2 <= a1 * c1;
      a2 <= a1;
      b2 <= b1;
      c2 <= c1;
      az2 <= (a1 == '0);
      bz2 <= (b1 == '0);
      rad <= (az2 || d_neg) ? '0 : {1'b0, d[MW-1:0], {(2*FRAC_BITS){1'b0}}};
      a_zero <= az2;
      status <= status_next;
      den <= az2 ? {b2[W-1], b2} : {a2, 1'b0};
      nb_sc <= -b_sc;
      nc_sc <= -c_sc;
    end
  end

endmodule

@@ rtl/qrs_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_isqrt #(
  parameter int ROOT_BITS = 33,
  parameter int SIDE_WIDTH = 1,
  localparam int RAD_WIDTH = 2 * ROOT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [RAD_WIDTH-1:0]  rad,
  input  logic [SIDE_WIDTH-1:0] side_in,
  output logic                  out_valid,
  output logic [ROOT_BITS-1:0]  root,
  output logic [SIDE_WIDTH-1:0] side_out
);

  localparam int QW = ROOT_BITS;
  localparam int RW = RAD_WIDTH;
  localparam int RRW = QW + 3;

  logic [RW-1:0]         rad_q  [QW];
  logic [QW-1:0]         q_q    [QW];
  logic [RRW-1:0]        r_q    [QW];
  logic [SIDE_WIDTH-1:0] side_q [QW];
  logic                  v_q    [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [RW-1:0]         rad_i;
    logic [QW-1:0]         q_i;
    logic [RRW-1:0]        r_i, r_sh, t, r_next;
    logic [SIDE_WIDTH-1:0] side_i;
    logic                  v_i, ge;

    if (i == 0) begin : g_first
      assign rad_i = rad;
      assign q_i = '0;
      assign r_i = '0;
      assign side_i = side_in;
      assign v_i = in_valid;
    end else begin : g_next
      assign rad_i = rad_q[i-1];
      assign q_i = q_q[i-1];
      assign r_i = r_q[i-1];
      assign side_i = side_q[i-1];
      assign v_i = v_q[i-1];
    end

    assign r_sh = {r_i[RRW-3:0], rad_i[RW-1 -: 2]};
    assign t = {1'b0, q_i, 2'b01};
    assign ge = (r_sh >= t);
    assign r_next = ge ? (r_sh - t) : r_sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[i] <= rad_i << 2;
        q_q[i] <= {q_i[QW-2:0], ge};
        r_q[i] <= r_next;
        side_q[i] <= side_i;
      end
    end
  end

  assign out_valid = v_q[QW-1];
  assign root = q_q[QW-1];
  assign side_out = side_q[QW-1];

endmodule

@@ rtl/qrs_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined signed divider, truncating toward zero, one quotient bit a stage.
// ----------------------------------------------------------------------------
module qrs_div #(
  parameter int NUM_WIDTH = 35,
  parameter int DEN_WIDTH = 17,
  parameter int SIDE_WIDTH = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [NUM_WIDTH-1:0] num,
  input  logic signed [DEN_WIDTH-1:0] den,
  input  logic [SIDE_WIDTH-1:0]       side_in,
  output logic                        out_valid,
  output logic signed [NUM_WIDTH:0]   quot,
  output logic [SIDE_WIDTH-1:0]       side_out
);

  localparam int NW = NUM_WIDTH;
  localparam int DNW = DEN_WIDTH;

  // Magnitude stage.
  logic                  va, nega;
  logic [NW-1:0]         na;
  logic [DNW-1:0]        da;
  logic [SIDE_WIDTH-1:0] sidea;

  logic [NW-1:0]         n_q    [NW];
  logic [DNW-1:0]        r_q    [NW];
  logic [DNW-1:0]        d_q    [NW];
  logic                  neg_q  [NW];
  logic [SIDE_WIDTH-1:0] side_q [NW];
  logic                  v_q    [NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      out_valid <= v_q[NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na <= num[NW-1] ? NW'(-num) : NW'(num);
      da <= den[DNW-1] ? DNW'(-den) : DNW'(den);
      nega <= num[NW-1] ^ den[DNW-1];
      sidea <= side_in;
      quot <= neg_q[NW-1] ? -$signed({1'b0, n_q[NW-1]}) : $signed({1'b0, n_q[NW-1]});
      side_out <= side_q[NW-1];
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [NW-1:0]         n_i;
    logic [DNW-1:0]        r_i, d_i;
    logic [DNW:0]          r_sh, r_sub;
    logic                  neg_i, v_i, ge;
    logic [SIDE_WIDTH-1:0] side_i;

    if (i == 0) begin : g_first
      assign n_i = na;
      assign r_i = '0;
      assign d_i = da;
      assign neg_i = nega;
      assign side_i = sidea;
      assign v_i = va;
    end else begin : g_next
      assign n_i = n_q[i-1];
      assign r_i = r_q[i-1];
      assign d_i = d_q[i-1];
      assign neg_i = neg_q[i-1];
      assign side_i = side_q[i-1];
      assign v_i = v_q[i-1];
    end

    assign r_sh = {r_i, n_i[NW-1]};
    assign ge = (r_sh >= {1'b0, d_i});
    assign r_sub = r_sh - {1'b0, d_i};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_q[i] <= {n_i[NW-2:0], ge};
        r_q[i] <= ge ? r_sub[DNW-1:0] : r_sh[DNW-1:0];
        d_q[i] <= d_i;
        neg_q[i] <= neg_i;
        side_q[i] <= side_i;
      end
    end
  end

endmodule

@@ rtl/qrs_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_back
// Saturation of both quotients, then ordering and zeroing (2 stages).
// ----------------------------------------------------------------------------
module qrs_back #(
  parameter int QUOT_WIDTH = 36
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [QUOT_WIDTH-1:0] quot1,
  input  logic signed [QUOT_WIDTH-1:0] quot2,
  input  qrs_pkg::status_t             status,
  output logic                         out_valid,
  output qrs_pkg::result_t             result
);

  localparam int RTW = qrs_pkg::ROOT_WIDTH;
  localparam int QOW = QUOT_WIDTH;

  logic signed [RTW-1:0] sat1, sat2, s1, s2;
  logic                  v1;
  qrs_pkg::status_t      st1;

  if (QOW > RTW) begin : g_sat
    localparam logic signed [RTW-1:0] MaxV = {1'b0, {(RTW-1){1'b1}}};
    localparam logic signed [RTW-1:0] MinV = {1'b1, {(RTW-1){1'b0}}};
    logic ovf1, ovf2;
    assign ovf1 = (quot1[QOW-1:RTW-1] != {(QOW-RTW+1){quot1[QOW-1]}});
    assign ovf2 = (quot2[QOW-1:RTW-1] != {(QOW-RTW+1){quot2[QOW-1]}});
    assign sat1 = ovf1 ? (quot1[QOW-1] ? MinV : MaxV) : quot1[RTW-1:0];
    assign sat2 = ovf2 ? (quot2[QOW-1] ? MinV : MaxV) : quot2[RTW-1:0];
  end else begin : g_ext
    assign sat1 = RTW'(quot1);
    assign sat2 = RTW'(quot2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= sat1;
      s2 <= sat2;
      st1 <= status;
      result.status <= st1;
      unique case (st1)
        qrs_pkg::ST_ONE: begin
          result.lo <= s1;
          result.hi <= s1;
        end
        qrs_pkg::ST_TWO: begin
          result.lo <= (s1 <= s2) ? s1 : s2;
          result.hi <= (s1 <= s2) ? s2 : s1;
        end
        default: begin
          result.lo <= '0;
          result.hi <= '0;
        end
      endcase
    end
  end

endmodule

@@ rtl/qrs_outbuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_outbuf
// Two-entry result buffer that parts the pipeline from the output handshake.
// ----------------------------------------------------------------------------
module qrs_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  qrs_pkg::result_t wdata,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output qrs_pkg::result_t rdata
);

  qrs_pkg::result_t mem [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign pop = out_valid && out_ready;
  assign full = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

@@ rtl/qrs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks of the quadratic root solver, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [1:0]                            root_status,
  input logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_low,
  input logic signed [qrs_pkg::ROOT_WIDTH-1:0] root_high
);

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(root_status)
      && $stable(root_low) && $stable(root_high))
    else $error("result beat changed while stalled");

  // Without real roots both fields are zero.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (root_status == qrs_pkg::ST_NONE || root_status == qrs_pkg::ST_DEGEN)
      |-> root_low == '0 && root_high == '0)
    else $error("roots not zero without real roots");

  // A single root fills both fields.
  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && root_status == qrs_pkg::ST_ONE |-> root_low == root_high)
    else $error("single root differs between fields");

  // Two roots come in ascending order.
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && root_status == qrs_pkg::ST_TWO |-> root_low <= root_high)
    else $error("roots out of order");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .root_status (root_status),
  .root_low    (root_low),
  .root_high   (root_high)
);
